FILE: sv/bfsa_pkg.sv
// Shared types, widths and constants of the backlog feedback slot allocator.
`default_nettype none

package bfsa_pkg;

   localparam int FRAC_BITS_DEF = 8;
   localparam int QUEUE_DEPTH   = 2;

   localparam int USERS_W     = 24;
   localparam int BITS_W      = 32;
   localparam int BPS_W       = 16;
   localparam int SLOT_W      = 8;
   localparam int QREG_W      = 16;
   localparam int BIAS_W      = 24;
   localparam int GAIN_W      = 16;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;

   // gain x users and gain x backlog slots, both as signed products
   localparam int PROD_U_W = GAIN_W + USERS_W + 1;
   localparam int PROD_B_W = GAIN_W + BITS_W + 1;
   // target holds bias plus both floored products without overflow
   localparam int TGT_W    = PROD_B_W + 3;
   // a step clamped to +/- max_step
   localparam int DIFF_W   = QREG_W + 2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_INITIAL_SLOTS  = 3'd0,
      CSR_BIAS           = 3'd1,
      CSR_GAIN_USERS     = 3'd2,
      CSR_GAIN_BACKLOG   = 3'd3,
      CSR_MAX_STEP       = 3'd4,
      CSR_MIN_SLOTS      = 3'd5,
      CSR_MAX_SLOTS      = 3'd6,
      CSR_RESERVED_SLOTS = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [QREG_W-1:0] initial_slots;
      logic [BIAS_W-1:0] bias;
      logic [GAIN_W-1:0] gain_users;
      logic [GAIN_W-1:0] gain_backlog;
      logic [QREG_W-1:0] max_step;
      logic [SLOT_W-1:0] min_slots;
      logic [SLOT_W-1:0] max_slots;
      logic [SLOT_W-1:0] reserved_slots;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      initial_slots:  16'd2560,
      bias:           24'd2560,
      gain_users:     16'd256,
      gain_backlog:   16'd256,
      max_step:       16'd512,
      min_slots:      8'd0,
      max_slots:      8'd255,
      reserved_slots: 8'd0
   };

   typedef struct packed {
      logic [USERS_W-1:0] ready_users;
      logic [BITS_W-1:0]  backlog_bits;
      logic [BPS_W-1:0]   bits_per_slot;
      logic [SLOT_W-1:0]  avail_slots;
      logic [SLOT_W-1:0]  yellow_slots;
   } item_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_MULTIPLY,
      ST_TARGET,
      ST_STEP,
      ST_CLAMP,
      ST_EMIT
   } back_state_type;

   typedef struct packed {
      logic pop;
      logic div_start;
      logic ld_prod;
      logic ld_target;
      logic ld_diff;
      logic ld_alloc;
      logic ld_rsp;
   } back_ctrl_type;

endpackage

`default_nettype wire

FILE: sv/bfsa_chan_if.sv
// Request and response channel interfaces of the slot allocator.
`default_nettype none

interface bfsa_req_if;
   import bfsa_pkg::*;

   logic               valid;
   logic               ready;
   logic [USERS_W-1:0] ready_users;
   logic [BITS_W-1:0]  backlog_bits;
   logic [BPS_W-1:0]   bits_per_slot;
   logic [SLOT_W-1:0]  frame_slots;

   modport source (output valid, ready_users, backlog_bits, bits_per_slot, frame_slots,
                   input ready);
   modport sink   (input valid, ready_users, backlog_bits, bits_per_slot, frame_slots,
                   output ready);
endinterface

interface bfsa_rsp_if;
   import bfsa_pkg::*;

   logic              valid;
   logic              ready;
   logic [SLOT_W-1:0] online_slots;
   logic [SLOT_W-1:0] yellow_slots;
   logic [SLOT_W-1:0] access_slots;

   modport source (output valid, online_slots, yellow_slots, access_slots, input ready);
   modport sink   (input valid, online_slots, yellow_slots, access_slots, output ready);
endinterface

`default_nettype wire

FILE: sv/bfsa_front.sv
// Front end: takes request beats, fixes zero bits per slot and works out free slots.
`default_nettype none

module bfsa_front (
   input  logic                            clock,
   input  logic                            reset,
   bfsa_req_if.sink                        req,
   input  logic [bfsa_pkg::SLOT_W-1:0]     reserved_slots,
   output logic                            item_valid,
   output bfsa_pkg::item_type              item,
   input  logic                            item_ready
);
   import bfsa_pkg::*;

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   logic     accept;

   assign req.ready  = !valid_ff || item_ready;
   assign accept     = req.valid && req.ready;
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_comb begin
      item_in.ready_users   = req.ready_users;
      item_in.backlog_bits  = req.backlog_bits;
      item_in.bits_per_slot = (req.bits_per_slot == '0) ? BPS_W'(1) : req.bits_per_slot;
      item_in.avail_slots   = (req.frame_slots > reserved_slots) ?
                              SLOT_W'(req.frame_slots - reserved_slots) : '0;
      item_in.yellow_slots  = reserved_slots;
   end

   always_comb begin
      if (accept) begin
         valid_in = 1'b1;
      end else if (item_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

endmodule

`default_nettype wire

FILE: sv/bfsa_fifo.sv
// Short item queue between the front and back ends.
`default_nettype none

module bfsa_fifo #(
   parameter int DEPTH = bfsa_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   input  bfsa_pkg::item_type push_item,
   output logic               push_ready,
   output logic               pop_valid,
   output bfsa_pkg::item_type pop_item,
   input  logic               pop_ready
);
   import bfsa_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   item_type         mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             push, pop;

   assign push_ready = (cnt_ff != CNT_W'(DEPTH));
   assign pop_valid  = (cnt_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_item   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

FILE: sv/bfsa_div.sv
// Restoring divider, one quotient bit a cycle: backlog bits to fixed-point slots.
`default_nettype none

module bfsa_div #(
   parameter int FRAC_BITS = bfsa_pkg::FRAC_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [bfsa_pkg::BITS_W-1:0] dividend,
   input  logic [bfsa_pkg::BPS_W-1:0]  divisor,
   output logic                        done,
   output logic [bfsa_pkg::BITS_W-1:0] quotient
);
   import bfsa_pkg::*;

   localparam int N     = BITS_W + FRAC_BITS;
   localparam int CNT_W = $clog2(N);

   logic [N-1:0]     num_ff, num_in;
   logic [BPS_W-1:0] rem_ff, rem_in;
   logic [BPS_W-1:0] div_ff, div_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [BPS_W:0]   rem_sh, rem_sub;
   logic             ge;

   assign rem_sh  = {rem_ff, num_ff[N-1]};
   assign rem_sub = rem_sh - {1'b0, div_ff};
   assign ge      = (rem_sh >= {1'b0, div_ff});

   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         num_in  = {dividend, {FRAC_BITS{1'b0}}};
         rem_in  = '0;
         div_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         num_in = {num_ff[N-2:0], ge};
         rem_in = ge ? rem_sub[BPS_W-1:0] : rem_sh[BPS_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(N - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done = done_ff;
   // saturate quotients that spill over 32 bits
   assign quotient = (|num_ff[N-1:BITS_W]) ? '1 : num_ff[BITS_W-1:0];

endmodule

`default_nettype wire

FILE: sv/bfsa_back.sv
// Back end: sequencer for target, rate-limited step, clamp, rounding and response register.
`default_nettype none

module bfsa_back #(
   parameter int FRAC_BITS = bfsa_pkg::FRAC_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  bfsa_pkg::cfg_type           cfg,
   input  logic                        last_load,
   input  logic [bfsa_pkg::QREG_W-1:0] last_init,
   input  logic                        item_valid,
   input  bfsa_pkg::item_type          item,
   output logic                        item_ready,
   bfsa_rsp_if.source                  rsp
);
   import bfsa_pkg::*;

   localparam int LAST_W = (SLOT_W + FRAC_BITS > QREG_W) ? SLOT_W + FRAC_BITS : QREG_W;
   localparam int SUM_W  = LAST_W + 2;
   localparam int RND_W  = LAST_W + 1;
   localparam logic [RND_W-1:0] HALF = RND_W'(1) << (FRAC_BITS - 1);

   back_state_type state_ff, state_in;
   back_ctrl_type  ctrl;

   item_type                    job_ff;
   logic signed [PROD_U_W-1:0]  prod_u_ff;
   logic signed [PROD_B_W-1:0]  prod_b_ff;
   logic signed [TGT_W-1:0]     target_ff, target_in;
   logic signed [DIFF_W-1:0]    diff_ff, diff_in;
   logic [LAST_W-1:0]           last_ff, last_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [SLOT_W-1:0]           online_ff, yellow_ff, access_ff;
   logic [SLOT_W-1:0]           access_in;

   logic                        div_done;
   logic [BITS_W-1:0]           qslots;
   logic                        out_free;

   logic signed [TGT_W-1:0]     diff_full, last_ext, step_pos, step_neg, diff_sel;
   logic signed [SUM_W-1:0]     alloc_sum, lo_ext, hi_ext, alloc_lo, alloc_hi;
   logic [RND_W-1:0]            rnd, ra_full;

   bfsa_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (ctrl.div_start),
      .dividend (item.backlog_bits),
      .divisor  (item.bits_per_slot),
      .done     (div_done),
      .quotient (qslots)
   );

   assign out_free   = !rsp_valid_ff || rsp.ready;
   assign item_ready = ctrl.pop;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:     if (item_valid) state_in = ST_DIVIDE;
         ST_DIVIDE:   if (div_done) state_in = ST_MULTIPLY;
         ST_MULTIPLY: state_in = ST_TARGET;
         ST_TARGET:   state_in = ST_STEP;
         ST_STEP:     state_in = ST_CLAMP;
         ST_CLAMP:    state_in = ST_EMIT;
         ST_EMIT:     if (out_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      ctrl = '0;
      unique case (state_ff)
         ST_IDLE: begin
            ctrl.pop       = 1'b1;
            ctrl.div_start = item_valid;
         end
         ST_DIVIDE:   ctrl.ld_prod   = div_done;
         ST_MULTIPLY: ctrl.ld_target = 1'b1;
         ST_TARGET:   ctrl.ld_diff   = 1'b1;
         ST_STEP:     ctrl.ld_alloc  = 1'b1;
         ST_CLAMP:    ctrl = '0;
         ST_EMIT:     ctrl.ld_rsp    = out_free;
         default:     ctrl = '0;
      endcase
   end

   // target = bias + floor(gu*users) - floor(gb*qslots)
   assign target_in = TGT_W'($signed(cfg.bias))
                    + TGT_W'(prod_u_ff >>> FRAC_BITS)
                    - TGT_W'(prod_b_ff >>> FRAC_BITS);

   // step toward target limited to +/- max_step
   assign last_ext  = $signed(TGT_W'(last_ff));
   assign step_pos  = $signed(TGT_W'(cfg.max_step));
   assign step_neg  = -step_pos;
   assign diff_full = target_ff - last_ext;

   always_comb begin
      if (diff_full > step_pos) begin
         diff_sel = step_pos;
      end else if (diff_full < step_neg) begin
         diff_sel = step_neg;
      end else begin
         diff_sel = diff_full;
      end
   end
   assign diff_in = DIFF_W'(diff_sel);

   // lower bound first, so max_slots wins when below min_slots
   assign alloc_sum = $signed(SUM_W'(last_ff)) + SUM_W'(diff_ff);
   assign lo_ext    = $signed(SUM_W'({cfg.min_slots, {FRAC_BITS{1'b0}}}));
   assign hi_ext    = $signed(SUM_W'({cfg.max_slots, {FRAC_BITS{1'b0}}}));
   assign alloc_lo  = (alloc_sum < lo_ext) ? lo_ext : alloc_sum;
   assign alloc_hi  = (alloc_lo > hi_ext) ? hi_ext : alloc_lo;

   always_comb begin
      if (last_load) begin
         last_in = LAST_W'(last_init);
      end else if (ctrl.ld_alloc) begin
         last_in = LAST_W'(alloc_hi);
      end else begin
         last_in = last_ff;
      end
   end

   // round half up, then limit to the free slots
   assign rnd       = RND_W'(last_ff) + HALF;
   assign ra_full   = rnd >> FRAC_BITS;
   assign access_in = (ra_full > RND_W'(job_ff.avail_slots)) ?
                      job_ff.avail_slots : ra_full[SLOT_W-1:0];

   always_comb begin
      if (ctrl.ld_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         last_ff      <= LAST_W'(CFG_RESET.initial_slots);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         last_ff      <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.div_start) begin
         job_ff <= item;
      end
      if (ctrl.ld_prod) begin
         prod_u_ff <= $signed(cfg.gain_users) * $signed({1'b0, job_ff.ready_users});
         prod_b_ff <= $signed(cfg.gain_backlog) * $signed({1'b0, qslots});
      end
      if (ctrl.ld_target) begin
         target_ff <= target_in;
      end
      if (ctrl.ld_diff) begin
         diff_ff <= diff_in;
      end
      if (ctrl.ld_rsp) begin
         access_ff <= access_in;
         online_ff <= job_ff.avail_slots - access_in;
         yellow_ff <= job_ff.yellow_slots;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.online_slots = online_ff;
   assign rsp.yellow_slots = yellow_ff;
   assign rsp.access_slots = access_ff;

endmodule

`default_nettype wire

FILE: sv/backlog_feedback_slot_allocator.sv
// Top level of the backlog feedback slot allocator: register file, front, queue and back.
//
// Use: once per frame send one request beat on req_ch (predicted ready users, total
// backlog in bits, bits per slot, frame size); one response beat follows on rsp_ch with
// the online, yellow and random access slot counts.
// A request passes the front register and the queue; the back end then runs the
// serial divider, one quotient bit a cycle over 32 + FRAC_BITS bits, then the
// multiply, target, step and clamp states, and loads the response register.
// The back end takes one item at a time; the front register and a QUEUE_DEPTH-entry
// queue keep taking request beats while the back end works, until they are full.
// Registers are written through csr_we/csr_index/csr_wdata; the user keeps the block
// idle meanwhile, which the block does not enforce. Writing initial_slots also
// reloads the kept allocation. Reset (synchronous, active high) loads the register
// defaults, sets the kept allocation to the initial_slots default and empties all stages.
// If the receiver stalls, the response stays in its output register, the back end
// holds its next result, and the queue and front fill before req_ch.ready drops.
`default_nettype none

module backlog_feedback_slot_allocator #(
   parameter int FRAC_BITS   = bfsa_pkg::FRAC_BITS_DEF,
   parameter int QUEUE_DEPTH = bfsa_pkg::QUEUE_DEPTH
) (
   input  logic                             clock,
   input  logic                             reset,
   bfsa_req_if.sink                         req_ch,
   bfsa_rsp_if.source                       rsp_ch,
   input  logic                             csr_we,
   input  logic [bfsa_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [bfsa_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import bfsa_pkg::*;

   cfg_type  cfg_ff, cfg_in;
   logic     last_load;

   logic     fr_valid, fr_ready;
   item_type fr_item;
   logic     q_valid, q_ready;
   item_type q_item;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_INITIAL_SLOTS:  cfg_in.initial_slots  = csr_wdata[QREG_W-1:0];
            CSR_BIAS:           cfg_in.bias           = csr_wdata[BIAS_W-1:0];
            CSR_GAIN_USERS:     cfg_in.gain_users     = csr_wdata[GAIN_W-1:0];
            CSR_GAIN_BACKLOG:   cfg_in.gain_backlog   = csr_wdata[GAIN_W-1:0];
            CSR_MAX_STEP:       cfg_in.max_step       = csr_wdata[QREG_W-1:0];
            CSR_MIN_SLOTS:      cfg_in.min_slots      = csr_wdata[SLOT_W-1:0];
            CSR_MAX_SLOTS:      cfg_in.max_slots      = csr_wdata[SLOT_W-1:0];
            CSR_RESERVED_SLOTS: cfg_in.reserved_slots = csr_wdata[SLOT_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign last_load = csr_we && (csr_index == CSR_INITIAL_SLOTS);

   bfsa_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req            (req_ch),
      .reserved_slots (cfg_ff.reserved_slots),
      .item_valid     (fr_valid),
      .item           (fr_item),
      .item_ready     (fr_ready)
   );

   bfsa_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fr_valid),
      .push_item  (fr_item),
      .push_ready (fr_ready),
      .pop_valid  (q_valid),
      .pop_item   (q_item),
      .pop_ready  (q_ready)
   );

   bfsa_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .last_load  (last_load),
      .last_init  (csr_wdata[QREG_W-1:0]),
      .item_valid (q_valid),
      .item       (q_item),
      .item_ready (q_ready),
      .rsp        (rsp_ch)
   );

endmodule

`default_nettype wire

FILE: sv/bfsa_checker.sv
// Port-level checks of the slot allocator and their bind to the top level.
`default_nettype none

module bfsa_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [bfsa_pkg::SLOT_W-1:0]   online_slots,
   input logic [bfsa_pkg::SLOT_W-1:0]   yellow_slots,
   input logic [bfsa_pkg::SLOT_W-1:0]   access_slots
);
   import bfsa_pkg::*;

   logic [7:0] pending_ff, pending_in;
   logic       req_beat, rsp_beat;

   assign req_beat = req_valid && req_ready;
   assign rsp_beat = rsp_valid && rsp_ready;

   always_comb begin
      pending_in = pending_ff;
      if (req_beat && !rsp_beat) begin
         pending_in = pending_ff + 1'b1;
      end else if (rsp_beat && !req_beat) begin
         pending_in = pending_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // no response beat left over after reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // every response beat answers an earlier request beat
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_beat |-> (pending_ff != '0))
      else $error("response beat without an outstanding request");

   // online, yellow and granted slots sum to at most 255 whenever any are granted or online
   a_slot_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((online_slots == '0 && access_slots == '0) ||
                     ({2'b00, online_slots} + {2'b00, access_slots} + {2'b00, yellow_slots}
                      <= 10'd255)))
      else $error("slot counts exceed the frame");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(online_slots) &&
                                  $stable(yellow_slots) && $stable(access_slots))
      else $error("stalled response beat changed");

endmodule

bind backlog_feedback_slot_allocator bfsa_checker u_bfsa_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_ch.valid),
   .req_ready    (req_ch.ready),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .online_slots (rsp_ch.online_slots),
   .yellow_slots (rsp_ch.yellow_slots),
   .access_slots (rsp_ch.access_slots)
);

`default_nettype wire
